>>> hw/rtl/sfd_pkg.sv
// sfd_pkg: types and constants shared by the sensor frame deframer modules
// no dependencies; imported by sfd_front, sfd_queue, sfd_back and the top level

package sfd_pkg;

    // frame layout
    localparam int FRAME_LENGTH = 17;
    localparam int STORE_DEPTH  = 16;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int POS_W        = $clog2(FRAME_LENGTH);
    localparam int NUM_FIELDS   = 7;
    localparam int FIELD_W      = 16;
    localparam int DATA_W       = NUM_FIELDS * FIELD_W;

    // last byte of a frame (the checksum byte) and the end marker slot
    localparam logic [POS_W-1:0]    LAST_POS    = POS_W'(FRAME_LENGTH - 1);
    localparam logic [STORE_AW-1:0] END_MRK_POS = STORE_AW'(FRAME_LENGTH - 2);

    // marker reset values
    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic [7:0] END_MARKER_RST   = 8'hFF;

    // configuration register indexes
    localparam logic CFG_START_MARKER = 1'b0;
    localparam logic CFG_END_MARKER   = 1'b1;

    // result queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // receive phases
    typedef enum logic [1:0] {
        PH_EXPECT  = 2'd0,
        PH_HUNT    = 2'd1,
        PH_SKIP    = 2'd2,
        PH_COLLECT = 2'd3
    } t_rx_phase;

    // marker settings
    typedef struct packed {
        logic [7:0] start_mark;
        logic [7:0] end_mark;
    } t_markers;

    // one finished frame
    typedef struct packed {
        logic              frame_good;
        logic [DATA_W-1:0] fields;
    } t_result;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

>>> hw/rtl/sfd_front.sv
// sfd_front: byte receiver, resync state machine, frame store and frame check
// depends on sfd_pkg

module sfd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sfd_pkg::t_markers      i_markers,
    input  logic                   i_byte_valid,
    output logic                   o_byte_ready,
    input  logic [7:0]             i_byte,
    input  sfd_pkg::t_queue_status i_queue_status,
    output logic                   o_push,
    output sfd_pkg::t_result       o_result
);
    import sfd_pkg::*;

    t_rx_phase          r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_first, n_first;
    logic [7:0]         r_store [STORE_DEPTH];
    logic               store_we;
    logic               xfer;
    logic               frame_done;

    // a byte transfer needs room for a possible result
    assign o_byte_ready = !i_queue_status.full;
    assign xfer         = i_byte_valid && o_byte_ready;
    assign frame_done   = (r_phase == PH_COLLECT) && (r_pos == LAST_POS);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (xfer) begin
            case (r_phase)
                PH_EXPECT: begin
                    n_phase = (i_byte == i_markers.start_mark) ? PH_COLLECT : PH_HUNT;
                end
                PH_HUNT: begin
                    if (i_byte == i_markers.end_mark) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_COLLECT;
                end
                PH_COLLECT: begin
                    if (r_pos == LAST_POS) begin
                        n_phase = PH_EXPECT;
                    end
                end
                default: begin
                    n_phase = PH_EXPECT;
                end
            endcase
        end
    end

    // position, running xor, first byte and store write
    always_comb begin
        n_pos    = r_pos;
        n_xor    = r_xor;
        n_first  = r_first;
        store_we = 1'b0;
        if (xfer) begin
            case (r_phase)
                PH_EXPECT: begin
                    if (i_byte == i_markers.start_mark) begin
                        n_first = i_byte;
                        n_xor   = i_byte;
                        n_pos   = POS_W'(1);
                    end
                end
                PH_SKIP: begin
                    n_pos = '0;
                end
                PH_COLLECT: begin
                    if (r_pos == '0) begin
                        n_first = i_byte;
                        n_xor   = i_byte;
                        n_pos   = POS_W'(1);
                    end else if (r_pos == LAST_POS) begin
                        n_xor = '0;
                        n_pos = '0;
                    end else begin
                        n_xor    = r_xor ^ i_byte;
                        store_we = 1'b1;
                        n_pos    = r_pos + POS_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result push and frame check on the checksum byte
    always_comb begin
        o_push              = xfer && frame_done;
        o_result.frame_good = (r_first == i_markers.start_mark)
                           && (r_store[END_MRK_POS] == i_markers.end_mark)
                           && ((r_xor ^ i_byte) == 8'h00);
        for (int k = 0; k < NUM_FIELDS; k++) begin
            o_result.fields[k*FIELD_W +: FIELD_W] = {r_store[STORE_AW'(2*k + 2)],
                                                     r_store[STORE_AW'(2*k + 1)]};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EXPECT;
            r_pos   <= '0;
            r_xor   <= '0;
            r_first <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_xor   <= n_xor;
            r_first <= n_first;
        end
    end

    // frame store, written at the current position
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_pos[STORE_AW-1:0]] <= i_byte;
        end
    end

endmodule

>>> hw/rtl/sfd_queue.sv
// sfd_queue: short result queue between the front and the back
// depends on sfd_pkg

module sfd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  sfd_pkg::t_result       i_result,
    input  logic                   i_pop,
    output sfd_pkg::t_result       o_result,
    output sfd_pkg::t_queue_status o_status
);
    import sfd_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_status.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_result       = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QUEUE_AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QUEUE_AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

endmodule

>>> hw/rtl/sfd_back.sv
// sfd_back: output register driving the result stream
// depends on sfd_pkg

module sfd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sfd_pkg::t_result       i_result,
    input  sfd_pkg::t_queue_status i_queue_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output sfd_pkg::t_result       o_result
);
    import sfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // load when the register is empty or its transfer completes now
    assign o_pop    = !i_queue_status.empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_result;
        end
    end

endmodule

>>> hw/rtl/sensor_frame_deframer.sv
// sensor_frame_deframer: top level, marker registers and front/queue/back wiring
// depends on sfd_pkg, sfd_front, sfd_queue, sfd_back
//
//  channel   direction  ports                        contents
//  s stream  in         i_s_tvalid/o_s_tready        rx_byte
//  m stream  out        o_m_tvalid/i_m_tready        seven 16-bit fields, frame_good
//  cfg       in         i_cfg_valid/o_cfg_ready      index 0 start marker, 1 end marker
//
// one byte is taken per cycle; a frame result enters a two-entry queue on its
// checksum byte and from there loads the output register when that is free
// the input stalls only when that queue is full (output held back)
// reset is synchronous, active low, and leaves the block waiting for a start byte

module sensor_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] rx_byte
    // frame output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [111:0] o_m_tdata,    // [15:0] travelled_distance, [31:16] heading_raw,
                                       // [47:32] ir_front_right_raw,
                                       // [63:48] ir_middle_right_raw, [79:64] ir_rear_raw,
                                       // [95:80] sonar_front_raw,
                                       // [111:96] sonar_front_right_raw
    output logic [0:0]  o_m_tuser,     // [0] frame_good
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import sfd_pkg::*;

    t_markers      r_markers;
    t_result       front_result;
    t_result       queue_result;
    t_result       back_result;
    t_queue_status queue_status;
    logic          push;
    logic          pop;

    // marker registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_markers.start_mark <= START_MARKER_RST;
            r_markers.end_mark   <= END_MARKER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_MARKER: r_markers.start_mark <= i_cfg_data;
                CFG_END_MARKER:   r_markers.end_mark   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sfd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_markers      (r_markers),
        .i_byte_valid   (i_s_tvalid),
        .o_byte_ready   (o_s_tready),
        .i_byte         (i_s_tdata),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_result       (front_result)
    );

    sfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (front_result),
        .i_pop    (pop),
        .o_result (queue_result),
        .o_status (queue_status)
    );

    sfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_result       (queue_result),
        .i_queue_status (queue_status),
        .o_pop          (pop),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_result       (back_result)
    );

    // stream payload
    assign o_m_tdata    = back_result.fields;
    assign o_m_tuser[0] = back_result.frame_good;

endmodule

>>> tb/sfd_frame_checker.sv
// sfd_frame_checker: watches the byte, frame and config channels of the deframer,
// predicts every frame result and compares it field by field with the output
// depends on sfd_pkg; instantiated by tb_sensor_frame_deframer
`timescale 1ns / 1ps

module sfd_frame_checker
    import sfd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte channel
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,
    // frame channel
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [111:0] i_m_tdata,
    input  logic [0:0]   i_m_tuser,
    // config channel
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    // status for the top
    output int           o_fail_count,
    output int           o_pending
);

    // predicted receiver state and marker settings
    t_markers         markers;
    t_rx_phase        rx_phase;
    logic [POS_W-1:0] frame_pos;
    logic [7:0]       frame_xor;
    logic [7:0]       lead_byte;
    logic [7:0]       frame_bytes [STORE_DEPTH];
    t_result          expected_frames [$];
    int               fail_tally;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_tally   = 0;
    end

    // advance the framing state by one received byte, queue a result on the checksum byte
    task automatic take_byte(input logic [7:0] b);
        t_result r;
        case (rx_phase)
            PH_EXPECT: begin
                if (b == markers.start_mark) begin
                    lead_byte = b;
                    frame_xor = b;
                    frame_pos = POS_W'(1);
                    rx_phase  = PH_COLLECT;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_HUNT: begin
                if (b == markers.end_mark)
                    rx_phase = PH_SKIP;
            end
            PH_SKIP: begin
                // byte after the end marker is dropped, the next one is forced to byte 0
                frame_pos = '0;
                rx_phase  = PH_COLLECT;
            end
            default: begin
                if (frame_pos == '0) begin
                    lead_byte = b;
                    frame_xor = b;
                    frame_pos = POS_W'(1);
                end else if (frame_pos < LAST_POS) begin
                    frame_xor = frame_xor ^ b;
                    frame_bytes[frame_pos[STORE_AW-1:0]] = b;
                    frame_pos = frame_pos + POS_W'(1);
                end else begin
                    frame_xor = frame_xor ^ b;
                    for (int k = 0; k < NUM_FIELDS; k++)
                        r.fields[k*FIELD_W +: FIELD_W] = {frame_bytes[2*k+2], frame_bytes[2*k+1]};
                    r.frame_good = (lead_byte == markers.start_mark) &&
                                   (frame_bytes[END_MRK_POS] == markers.end_mark) &&
                                   (frame_xor == 8'h00);
                    expected_frames.push_back(r);
                    rx_phase  = PH_EXPECT;
                    frame_pos = '0;
                    frame_xor = 8'h00;
                end
            end
        endcase
    endtask

    // compare one output transfer with the oldest predicted frame
    task automatic check_frame_result();
        t_result     want;
        logic [7:0]  bad;
        if (expected_frames.size() == 0) begin
            $display("%0t: unexpected frame result, expected none, actual %h good %b",
                     $time, i_m_tdata, i_m_tuser[0]);
            fail_tally++;
        end else begin
            want = expected_frames.pop_front();
            for (int k = 0; k < NUM_FIELDS; k++)
                bad[k] = want.fields[k*FIELD_W +: FIELD_W] !== i_m_tdata[k*FIELD_W +: FIELD_W];
            bad[7] = want.frame_good !== i_m_tuser[0];
            if (bad != 8'h00) begin
                $display("%0t: frame result mismatch (fields %b), expected %h good %b, actual %h good %b",
                         $time, bad, want.fields, want.frame_good, i_m_tdata, i_m_tuser[0]);
                fail_tally++;
            end
        end
    endtask

    // observe all three channels once per clock
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            markers.start_mark = START_MARKER_RST;
            markers.end_mark   = END_MARKER_RST;
            rx_phase  = PH_EXPECT;
            frame_pos = '0;
            frame_xor = 8'h00;
            lead_byte = 8'h00;
            for (int k = 0; k < STORE_DEPTH; k++)
                frame_bytes[k] = 8'h00;
            expected_frames.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_START_MARKER)
                    markers.start_mark = i_cfg_data;
                else
                    markers.end_mark = i_cfg_data;
            end
            // results leave through the queue and the output register after their checksum byte, so pop before push
            if (i_m_tvalid && i_m_tready)
                check_frame_result();
            if (i_s_tvalid && i_s_tready)
                take_byte(i_s_tdata);
        end
        o_pending    <= expected_frames.size();
        o_fail_count <= fail_tally;
    end

endmodule

>>> tb/tb_sensor_frame_deframer.sv
// tb_sensor_frame_deframer: stimulus, flow control and verdict for the frame deframer
// depends on sfd_pkg, sensor_frame_deframer and sfd_frame_checker
`timescale 1ns / 1ps

module tb_sensor_frame_deframer;
    import sfd_pkg::*;

    typedef enum int { FLAW_NONE, FLAW_SUM, FLAW_END } t_flaw;

    localparam int BYTES_PER_PHASE = 220;
    localparam int NUM_PHASES      = 7;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 8;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata   = 8'h00;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [111:0] o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = CFG_START_MARKER;
    logic [7:0]   i_cfg_data  = 8'h00;

    int           fail_count;
    int           pending;

    // stimulus-side view of the markers and flow control knobs
    logic [7:0]   start_mark  = START_MARKER_RST;
    logic [7:0]   end_mark    = END_MARKER_RST;
    int           bytes_sent  = 0;
    int           burst_left  = 0;
    bit           gaps_on     = 1'b0;
    int           stall_mode  = 0;
    bit           hold_req    = 1'b0;
    int           hold_left   = 0;

    sensor_frame_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sfd_frame_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver backpressure: long hold on request, else a pattern per stall mode
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // one byte transfer, with burst/gap idling when enabled
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (burst_left > 0)
            burst_left--;
        bytes_sent++;
    endtask

    // stop offering bytes and wait until every predicted result has been taken
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // marker register write, only with the block idle
    task automatic write_marker(input logic idx, input logic [7:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_START_MARKER)
            start_mark = val;
        else
            end_mark = val;
    endtask

    // full 17-byte frame; extreme payload puts all-zero and all-one fields out
    task automatic send_frame(input logic [7:0] first, input t_flaw flaw, input bit extreme);
        logic [7:0] fb [FRAME_LENGTH];
        logic [7:0] sum;
        fb[0] = first;
        for (int i = 1; i < FRAME_LENGTH - 2; i++)
            fb[i] = extreme ? ((i < 9) ? 8'h00 : 8'hFF) : 8'($urandom);
        fb[FRAME_LENGTH-2] = end_mark;
        if (flaw == FLAW_END)
            fb[FRAME_LENGTH-2] = end_mark ^ 8'($urandom_range(1, 255));
        sum = 8'h00;
        for (int i = 0; i < FRAME_LENGTH - 1; i++)
            sum = sum ^ fb[i];
        fb[FRAME_LENGTH-1] = sum;
        if (flaw == FLAW_SUM)
            fb[FRAME_LENGTH-1] = sum ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < FRAME_LENGTH; i++)
            send_byte(fb[i]);
    endtask

    // wrong opening byte, some noise, end marker, skipped byte, then a forced frame
    task automatic send_resync();
        logic [7:0] b;
        int         noise;
        b = 8'($urandom);
        if (b == start_mark)
            b = b ^ 8'h01;
        send_byte(b);
        noise = $urandom_range(0, 3);
        repeat (noise) begin
            b = 8'($urandom);
            if (b == end_mark)
                b = b ^ 8'h01;
            send_byte(b);
        end
        send_byte(end_mark);
        send_byte(8'($urandom));
        send_frame(($urandom_range(0, 1) != 0) ? start_mark : 8'($urandom),
                   ($urandom_range(0, 3) == 0) ? FLAW_SUM : FLAW_NONE, 1'b0);
    endtask

    // one random sequence, mostly well-formed frames
    task automatic send_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_frame(start_mark, FLAW_NONE, 1'b0);
        else if (pick < 70)
            send_frame(start_mark, FLAW_SUM, 1'b0);
        else if (pick < 78)
            send_frame(start_mark, FLAW_END, 1'b0);
        else if (pick < 94)
            send_resync();
        else
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
    endtask

    // main stimulus
    initial begin
        logic [7:0] set_start [NUM_PHASES];
        logic [7:0] set_end   [NUM_PHASES];

        set_start = '{START_MARKER_RST, 8'h00, 8'hFF, 8'($urandom), 8'hFF, 8'h00, 8'h5A};
        set_end   = '{END_MARKER_RST,   8'h00, 8'hFF, 8'($urandom), 8'h00, 8'hFF, 8'hC3};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: lost sync, resync on the end marker, forced first byte that fails
        send_byte(8'h00);
        send_byte(END_MARKER_RST);
        send_byte(8'h12);
        send_frame(8'h00, FLAW_NONE, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                write_marker(CFG_START_MARKER, set_start[p]);
                write_marker(CFG_END_MARKER, set_end[p]);
            end
            gaps_on    = (p % 2) != 0;
            burst_left = 0;
            stall_mode <= p % 3;
            // phase 1 opens on a good frame with extreme payload under the new markers
            if (p == 1)
                send_frame(start_mark, FLAW_NONE, 1'b1);
            // receiver holds off while bytes keep coming, so the block backs up
            if (p == 2)
                hold_req <= 1'b1;
            while (bytes_sent < 20 + (p + 1) * BYTES_PER_PHASE)
                send_sequence();
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
